// ===== rtl/subset_sum_counter_macros.svh =====
// Assertion macros used by the checker file of the subset sum counter.
`ifndef SUBSET_SUM_COUNTER_MACROS_SVH
`define SUBSET_SUM_COUNTER_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define SSC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("subset_sum_counter: same-cycle check failed");

// Next-cycle implication, sampled on clk and held off during reset.
`define SSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("subset_sum_counter: next-cycle check failed");

`endif

// ===== rtl/ssc_pkg.sv =====
// Shared constants, types and state codes of the subset sum counter.
package ssc_pkg;

  // Sizes of the element list and of the arithmetic.
  localparam int MAX_ITEMS = 16;
  localparam int ELEM_W    = 16;
  localparam int SUM_W     = 21;
  localparam int MATCH_W   = 17;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int WALK_W    = MAX_ITEMS + 1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } ssc_state_t;

  // Controls from the sequencer to the shared adder.
  typedef struct packed {
    logic clear;
    logic op_valid;
    logic op_sub;
  } walk_ctl_t;

endpackage

// ===== rtl/subset_sum_counter.sv =====
// Top level of the subset sum counter.
//
//   channel   ports                                  handshake
//   -------   ------------------------------------   -------------------------
//   input     element_value, last_element            start high, busy low
//   result    match_total, too_many_elements         done strobe, one cycle
//   config    target_sum                             target_sum_we
//
// A non-final element is taken and the block stays ready.
// The final element starts the walk of all 2^n subsets, where n is the number of
// stored elements; busy stays high and the shared adder does one step per subset.
// done rises in the last busy cycle. The receiver cannot stall the result.
// Synchronous reset clears the sequencer, the counts and target_sum to zero.
module subset_sum_counter
  import ssc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [ELEM_W-1:0] element_value,
  input  logic                     last_element,
  output logic                     done,
  output logic [MATCH_W-1:0]       match_total,
  output logic                     too_many_elements,
  input  logic                     target_sum_we,
  input  logic signed [SUM_W-1:0]  target_sum
);

  logic signed [SUM_W-1:0]  target;
  logic                     sum_pending;
  logic                     store_we;
  logic [IDX_W-1:0]         store_waddr;
  logic [MAX_ITEMS-1:0]     op_sel;
  logic signed [ELEM_W-1:0] operand;
  walk_ctl_t                ctl;

  // Target register.
  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
    end else if (target_sum_we) begin
      target <= target_sum;
    end
  end

  ssc_walk_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .last_element (last_element),
    .sum_pending  (sum_pending),
    .busy         (busy),
    .done         (done),
    .overflow     (too_many_elements),
    .store_we     (store_we),
    .store_waddr  (store_waddr),
    .op_sel       (op_sel),
    .ctl          (ctl)
  );

  ssc_elem_store u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (element_value),
    .rsel  (op_sel),
    .rdata (operand)
  );

  ssc_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .operand     (operand),
    .target      (target),
    .sum_pending (sum_pending),
    .match_total (match_total)
  );

endmodule

// ===== rtl/ssc_elem_store.sv =====
// Element register file with one write port and a one-hot selected read.
module ssc_elem_store
  import ssc_pkg::*;
(
  input  logic                     clk,
  input  logic                     we,
  input  logic [IDX_W-1:0]         waddr,
  input  logic signed [ELEM_W-1:0] wdata,
  input  logic [MAX_ITEMS-1:0]     rsel,
  output logic signed [ELEM_W-1:0] rdata
);

  logic signed [ELEM_W-1:0] mem [MAX_ITEMS];

  // Write the addressed entry.
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      if (we && (waddr == IDX_W'(i))) begin
        mem[i] <= wdata;
      end
    end
  end

  // The select is one-hot, so an AND-OR mux picks the entry.
  always_comb begin
    rdata = '0;
    for (int i = 0; i < MAX_ITEMS; i++) begin
      if (rsel[i]) begin
        rdata = rdata | mem[i];
      end
    end
  end

endmodule

// ===== rtl/ssc_accum.sv =====
// Shared add/subtract unit, running subset sum, target compare and match counter.
module ssc_accum
  import ssc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  walk_ctl_t                ctl,
  input  logic signed [ELEM_W-1:0] operand,
  input  logic signed [SUM_W-1:0]  target,
  output logic                     sum_pending,
  output logic [MATCH_W-1:0]       match_total
);

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] sum_next;
  logic signed [SUM_W-1:0] operand_ext;
  logic                    sum_valid;
  logic [MATCH_W-1:0]      hit_count;

  // Sign-extend the element and add or subtract it.
  assign operand_ext = {{(SUM_W - ELEM_W){operand[ELEM_W-1]}}, operand};
  assign sum_next    = ctl.op_sub ? (sum - operand_ext) : (sum + operand_ext);

  // Running sum; a fresh walk starts from the empty subset.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (ctl.clear) begin
      sum       <= '0;
      sum_valid <= 1'b1;
    end else begin
      sum_valid <= ctl.op_valid;
      if (ctl.op_valid) begin
        sum <= sum_next;
      end
    end
  end

  // Count each subset sum that hits the target, saturating at full scale.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count <= '0;
    end else if (ctl.clear) begin
      hit_count <= '0;
    end else if (sum_valid && (sum == target) && (hit_count != {MATCH_W{1'b1}})) begin
      hit_count <= hit_count + MATCH_W'(1);
    end
  end

  assign sum_pending = sum_valid;
  assign match_total = hit_count;

endmodule

// ===== rtl/ssc_walk_ctrl.sv =====
// Sequencer: loads elements and walks all subsets in Gray-code order.
module ssc_walk_ctrl
  import ssc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 last_element,
  input  logic                 sum_pending,
  output logic                 busy,
  output logic                 done,
  output logic                 overflow,
  output logic                 store_we,
  output logic [IDX_W-1:0]     store_waddr,
  output logic [MAX_ITEMS-1:0] op_sel,
  output walk_ctl_t            ctl
);

  ssc_state_t           state;
  ssc_state_t           state_next;
  logic [CNT_W-1:0]     count;
  logic [WALK_W-1:0]    k;
  logic [WALK_W-1:0]    limit;
  logic [MAX_ITEMS-1:0] gray;
  logic [MAX_ITEMS-1:0] gray_next;
  logic [MAX_ITEMS-1:0] flip;
  logic                 op_valid;
  logic                 op_sub;
  logic                 accept;
  logic                 room;
  logic                 issue;

  // The walk visits 2^n subsets; the lowest set bit of k picks the element to flip.
  assign limit     = WALK_W'(1) << count;
  assign flip      = k[MAX_ITEMS-1:0] & ~(k[MAX_ITEMS-1:0] - MAX_ITEMS'(1));
  assign gray_next = gray ^ flip;
  assign room      = (count < CNT_W'(MAX_ITEMS));
  assign issue     = (state == ST_WALK) && (k != limit);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_next = state;
    busy       = (state != ST_IDLE);
    done       = 1'b0;
    accept     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        accept = start;
        if (start && last_element) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if ((k == limit) && !op_valid && !sum_pending) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Element count, overflow flag, walk counter and the issued step.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
      op_valid <= 1'b0;
    end else begin
      op_valid <= 1'b0;
      if (accept) begin
        if (room) begin
          count <= count + CNT_W'(1);
        end else begin
          overflow <= 1'b1;
        end
        if (last_element) begin
          k    <= WALK_W'(1);
          gray <= '0;
        end
      end
      if (issue) begin
        k        <= k + WALK_W'(1);
        gray     <= gray_next;
        op_sel   <= flip;
        op_sub   <= ~|(gray_next & flip);
        op_valid <= 1'b1;
      end
      if (state == ST_DONE) begin
        count    <= '0;
        overflow <= 1'b0;
      end
    end
  end

  assign store_we     = accept && room;
  assign store_waddr  = count[IDX_W-1:0];
  assign ctl.clear    = accept && last_element;
  assign ctl.op_valid = op_valid;
  assign ctl.op_sub   = op_sub;

endmodule

// ===== rtl/ssc_checker.sv =====
// Port-level checks of the subset sum counter and their binding.
`include "subset_sum_counter_macros.svh"

module ssc_checker
  import ssc_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic                     last_element,
  input logic                     done,
  input logic [MATCH_W-1:0]       match_total,
  input logic                     too_many_elements
);

  // A non-final item leaves the block ready for the next one.
  `SSC_ASSERT_NEXT(a_load_stays_ready, start && !busy && !last_element, !busy)
  // The final item starts the walk.
  `SSC_ASSERT_NEXT(a_last_starts_walk, start && !busy && last_element, busy && !done)
  // The result appears only while the walk is still busy.
  `SSC_ASSERT_NOW(a_done_while_busy, done, busy)
  // After the result the block is ready again, with no repeated strobe.
  `SSC_ASSERT_NEXT(a_done_then_ready, done, !busy && !done)
  // While the block is idle and no item is offered, the result fields hold.
  `SSC_ASSERT_NEXT(a_idle_result_held, !busy && !start, $stable(match_total) && $stable(too_many_elements))

endmodule

bind subset_sum_counter ssc_checker u_checker (
  .clk               (clk),
  .rst               (rst),
  .start             (start),
  .busy              (busy),
  .last_element      (last_element),
  .done              (done),
  .match_total       (match_total),
  .too_many_elements (too_many_elements)
);
